### rtl/rprm_pkg.sv
// package for the read pair region matcher
// types and constants shared by the cell row and the top level, and the interval test of the cell row
`timescale 1ns / 1ps
`default_nettype none
package rprm_pkg;

  localparam int TableEntries = 32;
  localparam int LocusBits    = 10;
  localparam int IdxBits      = 5;
  localparam int CntBits      = $clog2(TableEntries + 1);

  localparam logic [1:0] KindBoth = 2'd0;
  localparam logic [1:0] KindRead = 2'd1;
  localparam logic [1:0] KindMate = 2'd2;

  localparam logic [15:0] MateDistReset = 16'd1000;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_HIT   = 6'b000010,
    ST_COM   = 6'b000100,
    ST_REST_R = 6'b001000,
    ST_REST_M = 6'b010000,
    ST_FLUSH = 6'b100000
  } state_e;

  typedef struct packed {
    logic [15:0] contig;
    logic [31:0] start;
    logic [31:0] stop;
    logic        target;
    logic [LocusBits-1:0] locus;
  } entry_t;

  typedef struct packed {
    logic [15:0] contig;
    logic [31:0] start;
    logic [31:0] stop;
  } span_t;

  typedef struct packed {
    logic  hit_ld;
    logic  adv;
    logic  mark_clr;
    logic  mark_set;
    logic [LocusBits-1:0] bus_locus;
    span_t rd;
    span_t mt;
  } cell_ctrl_t;

  typedef struct packed {
    logic tok;
    logic rh;
    logic mh;
    logic target;
    logic incom;
    logic eq;
    logic [LocusBits-1:0] locus;
  } cell_stat_t;

  function automatic logic covers(entry_t e, span_t s);
    logic ok;
    ok = (e.contig == s.contig) && (e.start <= s.start) && (s.stop <= e.stop) &&
         (e.start <= s.stop) && (e.stop >= s.start);
    return ok;
  endfunction

endpackage
`default_nettype wire

### rtl/rprm_cell.sv
// one cell of the region row: holds one table entry and its hit flags
// depends on rprm_pkg
`timescale 1ns / 1ps
`default_nettype none
module rprm_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rprm_pkg::cell_ctrl_t ctrl_i,
  input  logic                en_i,
  input  logic                wr_i,
  input  rprm_pkg::entry_t    wr_entry_i,
  input  logic                tok_i,
  output rprm_pkg::cell_stat_t stat_o
);

  rprm_pkg::entry_t ent_q;
  logic tok_q, rh_q, mh_q, incom_q;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      ent_q <= wr_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= 1'b0;
      rh_q    <= 1'b0;
      mh_q    <= 1'b0;
      incom_q <= 1'b0;
    end else begin
      if (ctrl_i.adv) begin
        tok_q <= tok_i;
      end
      if (ctrl_i.hit_ld) begin
        rh_q <= en_i && rprm_pkg::covers(ent_q, ctrl_i.rd);
        mh_q <= en_i && rprm_pkg::covers(ent_q, ctrl_i.mt);
      end
      if (ctrl_i.mark_clr) begin
        incom_q <= 1'b0;
      end else if (ctrl_i.mark_set && (ent_q.locus == ctrl_i.bus_locus)) begin
        incom_q <= 1'b1;
      end
    end
  end

  assign stat_o.tok    = tok_q;
  assign stat_o.rh     = rh_q;
  assign stat_o.mh     = mh_q;
  assign stat_o.target = ent_q.target;
  assign stat_o.incom  = incom_q;
  assign stat_o.eq     = (ent_q.locus == ctrl_i.bus_locus);
  assign stat_o.locus  = ent_q.locus;

endmodule
`default_nettype wire

### rtl/read_pair_region_matcher.sv
// top level of the read pair region matcher: stream ports, config port, sequencer
// depends on rprm_pkg and rprm_cell
`timescale 1ns / 1ps
`default_nettype none
// The block keeps a table of 32 regions in a row of cells, one entry per cell.
// A load transaction (tuser 0) writes one cell. A query transaction (tuser 1)
// first computes the read and mate hits in every cell at once, then a token
// walks down the row three times, one cell per cycle while the result side
// does not stall it: first for loci hit by both mates, then for the remaining
// read hits, then for the remaining mate hits. No new transaction is taken
// until a query has finished. Results leave through an output register held
// one result behind, so the final one can be marked with tlast; a query that
// matches nothing gives one result with found cleared. Config registers:
// regions_in_use at 0x0, max_mate_distance at 0x4; write them only while no
// query is in progress. The table comes up undefined after reset.
module read_pair_region_matcher (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // entry_index, entry_is_target, entry_locus, read_contig, read_start,
  // read_end, mate_contig, mate_start, mate_end
  input  logic [175:0] s_axis_tdata,
  // func
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // found, locus_index, is_target, input_kind, 2 bits zero fill
  output logic [15:0]  m_axis_tdata,
  output logic         m_axis_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int N  = rprm_pkg::TableEntries;
  localparam int LB = rprm_pkg::LocusBits;
  localparam int CB = rprm_pkg::CntBits;

  // config registers
  logic [5:0]  ru_q;
  logic [15:0] mmd_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = paddr[2] ? {16'd0, mmd_q} : {26'd0, ru_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ru_q  <= 6'd0;
      mmd_q <= rprm_pkg::MateDistReset;
    end else if (cfg_wr) begin
      if (!paddr[2]) begin
        ru_q <= pwdata[5:0];
      end else begin
        mmd_q <= pwdata[15:0];
      end
    end
  end

  // input unpacking
  logic [rprm_pkg::IdxBits-1:0] in_idx;
  rprm_pkg::entry_t  in_entry;
  rprm_pkg::span_t   in_rd, in_mt;
  logic              in_acc;

  assign in_idx          = s_axis_tdata[4:0];
  assign in_entry.target = s_axis_tdata[5];
  assign in_entry.locus  = s_axis_tdata[15:6];
  assign in_entry.contig = s_axis_tdata[31:16];
  assign in_entry.start  = s_axis_tdata[63:32];
  assign in_entry.stop   = s_axis_tdata[95:64];
  assign in_rd.contig    = s_axis_tdata[31:16];
  assign in_rd.start     = s_axis_tdata[63:32];
  assign in_rd.stop      = s_axis_tdata[95:64];
  assign in_mt.contig    = s_axis_tdata[111:96];
  assign in_mt.start     = s_axis_tdata[143:112];
  assign in_mt.stop      = s_axis_tdata[175:144];
  assign in_acc          = s_axis_tvalid && s_axis_tready;

  rprm_pkg::state_e state_q, state_d;
  rprm_pkg::span_t  rd_q, mt_q;
  logic             near_q, near_d;
  logic [CB-1:0]    nr_q, nm_q, nc_q, nr_d, nm_d, nc_d;

  assign s_axis_tready = (state_q == rprm_pkg::ST_IDLE);

  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tuser) begin
      rd_q <= in_rd;
      mt_q <= in_mt;
    end
  end

  // cell row
  rprm_pkg::cell_ctrl_t ctrl;
  rprm_pkg::cell_stat_t stat [N];
  logic                 tok_in [N];
  logic                 inject;
  logic [N-1:0]         tok_vec;

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign tok_in[i] = inject;
    end else begin : g_link
      assign tok_in[i] = stat[i-1].tok;
    end
    assign tok_vec[i] = stat[i].tok;
    rprm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .en_i       (6'(i) < ru_q),
      .wr_i       (in_acc && !s_axis_tuser && (in_idx == 5'(i))),
      .wr_entry_i (in_entry),
      .tok_i      (tok_in[i]),
      .stat_o     (stat[i])
    );
  end

  // one-hot mux of the token cell, and first mate hit of the bus locus
  logic          b_rh, b_mh, b_tgt, b_incom, any_m, f_tgt;
  logic [LB-1:0] b_loc;

  always_comb begin
    b_rh = 1'b0; b_mh = 1'b0; b_tgt = 1'b0; b_incom = 1'b0;
    b_loc = '0; any_m = 1'b0; f_tgt = 1'b0;
    for (int i = 0; i < N; i++) begin
      b_rh    = b_rh    | (stat[i].tok & stat[i].rh);
      b_mh    = b_mh    | (stat[i].tok & stat[i].mh);
      b_tgt   = b_tgt   | (stat[i].tok & stat[i].target);
      b_incom = b_incom | (stat[i].tok & stat[i].incom);
      b_loc   = b_loc   | ({LB{stat[i].tok}} & stat[i].locus);
    end
    // lowest matching mate hit wins
    for (int i = N - 1; i >= 0; i--) begin
      if (stat[i].mh && stat[i].eq) begin
        any_m = 1'b1;
        f_tgt = stat[i].target;
      end
    end
  end

  // output register and one pending result held back for tlast
  logic          out_v_q, out_v_d, out_found_q, out_tgt_q, out_last_q;
  logic [LB-1:0] out_loc_q;
  logic [1:0]    out_kind_q;
  logic          pv_q, pv_d, p_tgt_q;
  logic [LB-1:0] p_loc_q;
  logic [1:0]    p_kind_q;
  logic          out_free, gen, push, flush;
  logic          g_tgt;
  logic [1:0]    g_kind;
  logic          last_tok;
  logic [31:0]   start_gap;

  assign out_free  = !out_v_q || m_axis_tready;
  assign last_tok  = stat[N-1].tok;
  assign start_gap = (rd_q.start >= mt_q.start) ? (rd_q.start - mt_q.start)
                                                : (mt_q.start - rd_q.start);

  always_comb begin
    state_d = state_q;
    near_d  = near_q;
    nr_d = nr_q; nm_d = nm_q; nc_d = nc_q;
    inject  = 1'b0;
    gen     = 1'b0;
    flush   = 1'b0;
    g_tgt   = 1'b0;
    g_kind  = rprm_pkg::KindBoth;
    ctrl.hit_ld    = 1'b0;
    ctrl.adv       = 1'b0;
    ctrl.mark_clr  = 1'b0;
    ctrl.mark_set  = 1'b0;
    ctrl.bus_locus = b_loc;
    ctrl.rd        = rd_q;
    ctrl.mt        = mt_q;
    unique case (state_q)
      rprm_pkg::ST_IDLE: begin
        if (in_acc && s_axis_tuser) begin
          state_d = rprm_pkg::ST_HIT;
        end
      end
      rprm_pkg::ST_HIT: begin
        // compute hits and put the token on the first cell
        ctrl.hit_ld   = 1'b1;
        ctrl.adv      = 1'b1;
        ctrl.mark_clr = 1'b1;
        inject        = 1'b1;
        nr_d = '0; nm_d = '0; nc_d = '0;
        near_d  = (rd_q.contig == mt_q.contig) && (start_gap < {16'd0, mmd_q});
        state_d = rprm_pkg::ST_COM;
      end
      rprm_pkg::ST_COM: begin
        if (out_free) begin
          ctrl.adv = 1'b1;
          gen      = b_rh && any_m;
          g_tgt    = b_tgt | f_tgt;
          g_kind   = rprm_pkg::KindBoth;
          ctrl.mark_set = gen;
          nr_d = nr_q + CB'(b_rh);
          nm_d = nm_q + CB'(b_mh);
          nc_d = nc_q + CB'(gen);
          if (last_tok) begin
            inject  = 1'b1;
            state_d = rprm_pkg::ST_REST_R;
          end
        end
      end
      rprm_pkg::ST_REST_R: begin
        if (out_free) begin
          ctrl.adv = 1'b1;
          gen      = b_rh && (nc_q != nr_q) && !b_incom && (!near_q || b_tgt);
          g_tgt    = near_q | b_tgt;
          g_kind   = near_q ? rprm_pkg::KindRead : rprm_pkg::KindBoth;
          if (last_tok) begin
            inject  = 1'b1;
            state_d = rprm_pkg::ST_REST_M;
          end
        end
      end
      rprm_pkg::ST_REST_M: begin
        if (out_free) begin
          ctrl.adv = 1'b1;
          gen      = b_mh && (nc_q != nm_q) && !b_incom && (!near_q || b_tgt);
          g_tgt    = near_q | b_tgt;
          g_kind   = near_q ? rprm_pkg::KindMate : rprm_pkg::KindBoth;
          if (last_tok) begin
            state_d = rprm_pkg::ST_FLUSH;
          end
        end
      end
      rprm_pkg::ST_FLUSH: begin
        if (out_free) begin
          flush   = 1'b1;
          state_d = rprm_pkg::ST_IDLE;
        end
      end
      default: state_d = rprm_pkg::ST_IDLE;
    endcase
  end

  // a new result pushes the held one out; flush sends the held one, or an empty result if none is held, as last
  assign push    = (gen && pv_q) || flush;
  assign pv_d    = gen ? 1'b1 : (flush ? 1'b0 : pv_q);
  assign out_v_d = push ? 1'b1 : (out_v_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rprm_pkg::ST_IDLE;
      near_q  <= 1'b0;
      nr_q    <= '0;
      nm_q    <= '0;
      nc_q    <= '0;
      out_v_q <= 1'b0;
      pv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      near_q  <= near_d;
      nr_q    <= nr_d;
      nm_q    <= nm_d;
      nc_q    <= nc_d;
      out_v_q <= out_v_d;
      pv_q    <= pv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_found_q <= pv_q;
      out_loc_q   <= pv_q ? p_loc_q : '0;
      out_tgt_q   <= pv_q ? p_tgt_q : 1'b0;
      out_kind_q  <= pv_q ? p_kind_q : rprm_pkg::KindBoth;
      out_last_q  <= flush;
    end
    if (gen) begin
      p_loc_q  <= b_loc;
      p_tgt_q  <= g_tgt;
      p_kind_q <= g_kind;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {2'b00, out_kind_q, out_tgt_q, out_loc_q, out_found_q};
  assign m_axis_tlast  = out_last_q;

`ifndef ASSERT_OFF
  a_tok_onehot0 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vec)) else $error("more than one token in the cell row");
  a_tok_in_scan : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rprm_pkg::ST_COM || state_q == rprm_pkg::ST_REST_R ||
     state_q == rprm_pkg::ST_REST_M) |-> $onehot(tok_vec))
    else $error("scan running without a token");
  a_idle_no_pend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rprm_pkg::ST_IDLE) |-> !pv_q)
    else $error("held result left behind after a query");
  a_flush_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush |=> (m_axis_tvalid && m_axis_tlast))
    else $error("query closed without a last result");
`endif

endmodule
`default_nettype wire

### tb/read_pair_region_matcher_chk.sv
// checker for the read pair region matcher: watches the stream and config ports,
// predicts the routed loci of each query and compares them; uses rprm_pkg
`timescale 1ns / 1ps
module read_pair_region_matcher_chk #(
  parameter logic [2:0] AddrRegionsInUse = 3'h0,
  parameter logic [2:0] AddrMateDist     = 3'h4,
  parameter logic       FuncLoad         = 1'b0
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [175:0] s_axis_tdata,
  input  logic         s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [15:0]  m_axis_tdata,
  input  logic         m_axis_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           fail_count,
  output int           pending
);

  typedef struct {
    logic       found;
    logic [9:0] locus;
    logic       tgt;
    logic [1:0] kind;
    logic       last;
  } route_t;

  typedef struct {
    logic [9:0] locus;
    logic       tgt;
  } hit_t;

  logic [15:0] tab_contig [32];
  logic [31:0] tab_start  [32];
  logic [31:0] tab_stop   [32];
  logic        tab_tgt    [32];
  logic [9:0]  tab_locus  [32];
  logic [5:0]  regions_in_use;
  logic [15:0] mate_dist;
  route_t      route_q [$];

  assign pending = route_q.size();

  function automatic void collect(input logic [15:0] c, input logic [31:0] s,
                                  input logic [31:0] e, ref hit_t h[$]);
    int lim;
    lim = (regions_in_use > 32) ? 32 : regions_in_use;
    h.delete();
    for (int i = 0; i < lim; i++)
      if (tab_contig[i] == c && tab_start[i] <= s && e <= tab_stop[i] &&
          tab_start[i] <= e && tab_stop[i] >= s)
        h = {h, hit_t'{tab_locus[i], tab_tgt[i]}};
  endfunction

  // drop hits whose locus already went out as a common result
  function automatic void purge(ref hit_t h[$], input hit_t com[$]);
    hit_t kept [$];
    bit dup;
    if (com.size() == h.size()) begin
      h.delete();
      return;
    end
    foreach (h[i]) begin
      dup = 0;
      foreach (com[j]) if (h[i].locus == com[j].locus) dup = 1;
      if (!dup) kept = {kept, h[i]};
    end
    h = kept;
  endfunction

  function automatic void route_pair(input logic [175:0] d);
    hit_t rh [$], mh [$], com [$];
    route_t out [$];
    logic [31:0] start_gap;
    bit nearby;
    collect(d[31:16], d[63:32], d[95:64], rh);
    collect(d[111:96], d[143:112], d[175:144], mh);
    foreach (rh[i]) begin
      for (int j = 0; j < mh.size(); j++)
        if (rh[i].locus == mh[j].locus) begin
          com = {com, hit_t'{rh[i].locus, rh[i].tgt | mh[j].tgt}};
          break;
        end
    end
    foreach (com[i])
      out = {out, route_t'{1'b1, com[i].locus, com[i].tgt, rprm_pkg::KindBoth, 1'b0}};
    if (com.size() > 0) begin
      purge(rh, com);
      purge(mh, com);
    end
    start_gap = (d[63:32] >= d[143:112]) ? d[63:32] - d[143:112]
                                         : d[143:112] - d[63:32];
    nearby = (d[31:16] == d[111:96]) && (start_gap < {16'd0, mate_dist});
    if (nearby) begin
      // nearby mates: only target regions, tagged by side
      foreach (rh[i]) if (rh[i].tgt)
        out = {out, route_t'{1'b1, rh[i].locus, 1'b1, rprm_pkg::KindRead, 1'b0}};
      foreach (mh[i]) if (mh[i].tgt)
        out = {out, route_t'{1'b1, mh[i].locus, 1'b1, rprm_pkg::KindMate, 1'b0}};
    end else begin
      foreach (rh[i])
        out = {out, route_t'{1'b1, rh[i].locus, rh[i].tgt, rprm_pkg::KindBoth, 1'b0}};
      foreach (mh[i])
        out = {out, route_t'{1'b1, mh[i].locus, mh[i].tgt, rprm_pkg::KindBoth, 1'b0}};
    end
    if (out.size() == 0)
      out = {out, route_t'{1'b0, 10'd0, 1'b0, rprm_pkg::KindBoth, 1'b0}};
    out[out.size()-1].last = 1'b1;
    route_q = {route_q, out};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    route_t exp_r;
    if (!rst_ni) begin
      regions_in_use <= 6'd0;
      mate_dist      <= rprm_pkg::MateDistReset;
      fail_count     = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == AddrRegionsInUse) regions_in_use <= pwdata[5:0];
        else if (paddr == AddrMateDist) mate_dist <= pwdata[15:0];
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == FuncLoad) begin
          tab_contig[s_axis_tdata[4:0]] = s_axis_tdata[31:16];
          tab_start[s_axis_tdata[4:0]]  = s_axis_tdata[63:32];
          tab_stop[s_axis_tdata[4:0]]   = s_axis_tdata[95:64];
          tab_tgt[s_axis_tdata[4:0]]    = s_axis_tdata[5];
          tab_locus[s_axis_tdata[4:0]]  = s_axis_tdata[15:6];
        end else begin
          route_pair(s_axis_tdata);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (route_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result tdata=%h tlast=%b", $time, m_axis_tdata,
                   m_axis_tlast);
        end else begin
          exp_r = route_q.pop_front();
          if (m_axis_tdata[0] !== exp_r.found || m_axis_tdata[10:1] !== exp_r.locus ||
              m_axis_tdata[11] !== exp_r.tgt || m_axis_tdata[13:12] !== exp_r.kind ||
              m_axis_tlast !== exp_r.last) begin
            fail_count++;
            $display("%0t: mismatch exp found=%b locus=%0d tgt=%b kind=%0d last=%b",
                     $time, exp_r.found, exp_r.locus, exp_r.tgt, exp_r.kind, exp_r.last);
            $display("%0t:          got found=%b locus=%0d tgt=%b kind=%0d last=%b",
                     $time, m_axis_tdata[0], m_axis_tdata[10:1], m_axis_tdata[11],
                     m_axis_tdata[13:12], m_axis_tlast);
          end
        end
      end
    end
  end
endmodule

### tb/read_pair_region_matcher_tb.sv
// testbench top for the read pair region matcher: clock, reset, stimulus, verdict
// depends on rprm_pkg, read_pair_region_matcher and read_pair_region_matcher_chk
`timescale 1ns / 1ps
module read_pair_region_matcher_tb;
  localparam logic [2:0] AddrRegionsInUse = 3'h0;
  localparam logic [2:0] AddrMateDist     = 3'h4;
  localparam logic       FuncLoad         = 1'b0;
  localparam logic       FuncQuery        = 1'b1;
  localparam int         CycleLimit       = 1000000;
  localparam int         DrainCycles      = 150;   // a query walks the row three times

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // entry_index, entry_is_target, entry_locus, read_contig, read_start,
  // read_end, mate_contig, mate_start, mate_end
  logic [175:0] s_axis_tdata = '0;
  // func
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // found, locus_index, is_target, input_kind, zero fill
  logic [15:0]  m_axis_tdata;
  logic         m_axis_tlast;
  logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  int           fail_count, pending;
  bit           send_busy = 1'b1, recv_busy = 1'b1;  // random idling on or off
  int           cycles = 0;

  // stimulus-side copy of the table, used only to aim queries at regions
  logic [15:0]  reg_contig [32];
  logic [31:0]  reg_start  [32];
  logic [31:0]  reg_stop   [32];
  logic [9:0]   reg_locus  [32];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  read_pair_region_matcher dut (.*);

  read_pair_region_matcher_chk #(
    .AddrRegionsInUse(AddrRegionsInUse), .AddrMateDist(AddrMateDist), .FuncLoad(FuncLoad)
  ) chk (.*);

  // watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side: random stall before each transaction, none while recv_busy is low
  initial begin
    int n;
    forever begin
      n = recv_busy ? $urandom_range(0, 5) : 0;
      repeat (n) begin
        @(negedge clk_i);
        m_axis_tready = 1'b0;
      end
      @(negedge clk_i);
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  function automatic logic [175:0] pack_item(
      logic [4:0] idx, logic tgt, logic [9:0] locus,
      logic [15:0] rc, logic [31:0] rs, logic [31:0] re,
      logic [15:0] mc, logic [31:0] ms, logic [31:0] me);
    return {me, ms, mc, re, rs, rc, locus, tgt, idx};
  endfunction

  task automatic send(input logic func, input logic [175:0] d);
    int gap;
    gap = send_busy ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = d;
    s_axis_tuser  = func;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic load(input logic [4:0] idx, input logic tgt, input logic [9:0] locus,
                      input logic [15:0] c, input logic [31:0] s, input logic [31:0] e);
    reg_contig[idx] = c;
    reg_start[idx]  = s;
    reg_stop[idx]   = e;
    reg_locus[idx]  = locus;
    send(FuncLoad, pack_item(idx, tgt, locus, c, s, e, '0, '0, '0));
  endtask

  task automatic query(input logic [15:0] rc, input logic [31:0] rs, input logic [31:0] re,
                       input logic [15:0] mc, input logic [31:0] ms, input logic [31:0] me);
    send(FuncQuery, pack_item(5'($urandom), 1'($urandom), 10'($urandom),
                              rc, rs, re, mc, ms, me));
  endtask

  // wait until every result is in and the block has settled, then stay idle
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    drain();
    psel = 1'b1; pwrite = 1'b1; paddr = addr; pwdata = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // random region, mostly on a few contigs and small loci so hits and shared loci occur
  task automatic load_random(input logic [4:0] idx);
    logic [15:0] c;
    logic [31:0] s;
    if ($urandom_range(0, 9) == 0) begin
      s = $urandom;
      load(idx, 1'($urandom), 10'($urandom), 16'($urandom), s, s + $urandom);
    end else begin
      case ($urandom_range(0, 3))
        0: c = 16'hFFFF;
        1: c = 16'h7FFF;
        default: c = 16'($urandom_range(0, 2));
      endcase
      s = $urandom_range(0, 4000);
      load(idx, 1'($urandom), 10'($urandom_range(0, 7)), c, s, s + $urandom_range(0, 2000));
    end
  endtask

  // one side inside a loaded region, or anywhere
  task automatic pick_side(output logic [15:0] c, output logic [31:0] s,
                           output logic [31:0] e, input int lim);
    int k;
    logic [31:0] len;
    if ($urandom_range(0, 6) == 0 || lim == 0) begin
      c = ($urandom_range(0, 1)) ? 16'($urandom) : 16'($urandom_range(0, 2));
      s = $urandom;
      e = s + $urandom_range(0, 3000);
    end else begin
      k = $urandom_range(0, lim - 1);
      c = reg_contig[k];
      len = reg_stop[k] - reg_start[k];
      s = reg_start[k] + $urandom_range(0, len > 1000 ? 1000 : len);
      e = s + $urandom_range(0, 300);
      if (e > reg_stop[k] || e < s) e = reg_stop[k];
    end
  endtask

  task automatic query_random(input int lim);
    logic [15:0] rc, mc;
    logic [31:0] rs, re, ms, me;
    if ($urandom_range(0, 9) == 0) begin
      query(16'($urandom), $urandom, $urandom, 16'($urandom), $urandom, $urandom);
    end else begin
      pick_side(rc, rs, re, lim);
      pick_side(mc, ms, me, lim);
      query(rc, rs, re, mc, ms, me);
    end
  endtask

  task automatic random_phase(input int n, input logic [5:0] use_n,
                              input logic [15:0] mate_gap);
    int lim;
    cfg_write(AddrRegionsInUse, {26'd0, use_n});
    cfg_write(AddrMateDist, {16'd0, mate_gap});
    lim = (use_n > 32) ? 32 : use_n;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) load_random(5'($urandom));
      else query_random(lim);
    end
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // nothing in use: empty result
    query(16'd0, 32'd100, 32'd200, 16'd0, 32'd100, 32'd200);

    // directed table: overlapping loci, whole-range and extreme regions
    load(5'd0, 1'b1, 10'd1,    16'd0,      32'd100,        32'd500);
    load(5'd1, 1'b0, 10'd2,    16'd0,      32'd0,          32'd1000);
    load(5'd2, 1'b0, 10'd1,    16'd0,      32'd400,        32'd900);
    load(5'd3, 1'b1, 10'd1023, 16'hFFFF,   32'd0,          32'hFFFF_FFFF);
    load(5'd4, 1'b0, 10'd3,    16'h7FFF,   32'hFFFF_FF00,  32'hFFFF_FFFF);
    load(5'd5, 1'b1, 10'd0,    16'd1,      32'd0,          32'd0);
    load(5'd6, 1'b1, 10'd4,    16'd0,      32'd2000,       32'd3000);
    load(5'd31, 1'b1, 10'd5,   16'd0,      32'd0,          32'd5000);
    cfg_write(AddrRegionsInUse, 32'd7);

    query(16'd0, 32'd150, 32'd450, 16'd0, 32'd450, 32'd800);       // shared loci, nearby
    query(16'd0, 32'd150, 32'd450, 16'd0, 32'd2100, 32'd2200);     // far apart
    query(16'd0, 32'd150, 32'd160, 16'd0, 32'd2100, 32'd2200);     // far, no shared locus
    query(16'd0, 32'd200, 32'd300, 16'd0, 32'd600, 32'd700);       // nearby, shared loci
    query(16'hFFFF, 32'd0, 32'hFFFF_FFFF, 16'hFFFF, 32'd5, 32'd9); // both unmapped
    query(16'h7FFF, 32'hFFFF_FF00, 32'hFFFF_FFFF, 16'd1, 32'd0, 32'd0);
    query(16'd9, 32'd1, 32'd2, 16'd9, 32'd3, 32'd4);               // no region on contig
    query(16'd0, 32'd600, 32'd500, 16'd0, 32'd999, 32'd1001);      // reversed, too long

    cfg_write(AddrMateDist, 32'd0);
    query(16'd0, 32'd200, 32'd300, 16'd0, 32'd200, 32'd300);       // same start, never near
    cfg_write(AddrMateDist, 32'd65535);
    query(16'd0, 32'd200, 32'd300, 16'd0, 32'd2100, 32'd2200);

    // fill the whole table, then a spread of settings
    for (int i = 0; i < 32; i++) load_random(5'(i));
    random_phase(40, 6'd32, 16'd1000);
    random_phase(25, 6'd63, 16'd0);
    random_phase(25, 6'd1, 16'd65535);

    // burst with no idling at all on either side
    send_busy = 1'b0;
    recv_busy = 1'b0;
    random_phase(25, 6'd32, 16'($urandom));
    send_busy = 1'b1;
    recv_busy = 1'b1;

    // hold off until the block has emptied, then continue
    drain();
    random_phase(30, 6'd40, 16'($urandom_range(0, 3000)));
    random_phase(25, 6'($urandom_range(0, 32)), 16'($urandom));

    drain();
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
